// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked while reset is released.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/thc_pkg.sv =====
// Package with shared types and constants of the temperature and humidity compensation.
`default_nettype none
package thc_pkg;

    localparam int TEMP_STAGES = 4;
    localparam int HUM_STAGES  = 8;

    // Configuration register indexes.
    localparam logic [3:0] REG_TEMP_CAL_1      = 4'd0;
    localparam logic [3:0] REG_TEMP_CAL_2      = 4'd1;
    localparam logic [3:0] REG_TEMP_CAL_3      = 4'd2;
    localparam logic [3:0] REG_HUM_CAL_1_AND_3 = 4'd3;
    localparam logic [3:0] REG_HUM_CAL_2       = 4'd4;
    localparam logic [3:0] REG_HUM_CAL_4       = 4'd5;
    localparam logic [3:0] REG_HUM_CAL_5       = 4'd6;
    localparam logic [3:0] REG_HUM_CAL_6       = 4'd7;

    // Arithmetic constants of the compensation.
    localparam logic signed [31:0] C_TC_ROUND  = 32'sd128;
    localparam logic signed [31:0] C_TF_OFFSET = 32'sd76800;
    localparam logic signed [31:0] C_P_ROUND   = 32'sd16384;
    localparam logic signed [31:0] C_Q2_OFS    = 32'sd32768;
    localparam logic signed [31:0] C_Q_OFS     = 32'sd2097152;
    localparam logic signed [31:0] C_QH_ROUND  = 32'sd8192;
    localparam logic signed [31:0] C_HUM_MAX   = 32'sd419430400;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [7:0]  h1;
        logic        [7:0]  h3;
        logic signed [15:0] h2;
        logic        [11:0] h4;
        logic        [11:0] h5;
        logic signed [7:0]  h6;
    } t_cal;

    // Temperature result as it enters the humidity pipeline.
    typedef struct packed {
        logic        [15:0] rh;
        logic signed [31:0] tf;
        logic signed [31:0] x;
        logic        [23:0] tc;
    } t_temp_res;

endpackage
`default_nettype wire

// ===== sv/thc_cfg_regs.sv =====
// Calibration register file written through the configuration port.
`default_nettype none
module thc_cfg_regs
    import thc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output t_cal             o_cal
);

    t_cal r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEMP_CAL_1:      r_cal.t1 <= i_cfg_data;
                REG_TEMP_CAL_2:      r_cal.t2 <= i_cfg_data;
                REG_TEMP_CAL_3:      r_cal.t3 <= i_cfg_data;
                REG_HUM_CAL_1_AND_3: begin
                    r_cal.h1 <= i_cfg_data[7:0];
                    r_cal.h3 <= i_cfg_data[15:8];
                end
                REG_HUM_CAL_2:       r_cal.h2 <= i_cfg_data;
                REG_HUM_CAL_4:       r_cal.h4 <= i_cfg_data[11:0];
                REG_HUM_CAL_5:       r_cal.h5 <= i_cfg_data[11:0];
                REG_HUM_CAL_6:       r_cal.h6 <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cal = r_cal;

endmodule
`default_nettype wire

// ===== sv/thc_temp_pipe.sv =====
// Four-stage pipeline computing fine temperature and centidegree temperature.
`default_nettype none
module thc_temp_pipe
    import thc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cal        i_cal,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [19:0] i_raw_temperature,
    input  wire logic [15:0] i_raw_humidity,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_temp_res        o_res
);

    logic [TEMP_STAGES-1:0] r_v;
    logic [TEMP_STAGES-1:0] w_en;

    logic signed [31:0] w_t2, w_t3;
    logic signed [31:0] n_a, n_b;
    logic signed [31:0] r1_m1, r1_bb;
    logic signed [31:0] r2_v1, r2_m2;
    logic signed [31:0] r3_tf;
    logic signed [31:0] n_tc5, n_tcs;
    logic        [15:0] r1_rh, r2_rh, r3_rh;
    t_temp_res          r4_res;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        w_en[TEMP_STAGES-1] = !r_v[TEMP_STAGES-1] || !i_stall;
        for (int k = TEMP_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < TEMP_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign w_t2 = {{16{i_cal.t2[15]}}, i_cal.t2};
    assign w_t3 = {{16{i_cal.t3[15]}}, i_cal.t3};
    assign n_a  = {15'd0, i_raw_temperature[19:3]} - {15'd0, i_cal.t1, 1'b0};
    assign n_b  = {16'd0, i_raw_temperature[19:4]} - {16'd0, i_cal.t1};

    assign n_tc5 = r3_tf + (r3_tf <<< 2) + C_TC_ROUND;
    assign n_tcs = n_tc5 >>> 8;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_m1 <= n_a * w_t2;
            r1_bb <= n_b * n_b;
            r1_rh <= i_raw_humidity;
        end
        if (w_en[1]) begin
            r2_v1 <= r1_m1 >>> 11;
            r2_m2 <= (r1_bb >>> 12) * w_t3;
            r2_rh <= r1_rh;
        end
        if (w_en[2]) begin
            r3_tf <= r2_v1 + (r2_m2 >>> 14);
            r3_rh <= r2_rh;
        end
        if (w_en[3]) begin
            r4_res.rh <= r3_rh;
            r4_res.tf <= r3_tf;
            r4_res.x  <= r3_tf - C_TF_OFFSET;
            r4_res.tc <= n_tcs[23:0];
        end
    end

    assign o_valid = r_v[TEMP_STAGES-1];
    assign o_res   = r4_res;

endmodule
`default_nettype wire

// ===== sv/thc_hum_pipe.sv =====
// Eight-stage pipeline computing compensated humidity from the fine temperature.
`default_nettype none
module thc_hum_pipe
    import thc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cal        i_cal,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_temp_res   i_res,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [23:0]      o_temperature_centi,
    output logic [16:0]      o_humidity_q10,
    output logic [31:0]      o_fine_temperature
);

    logic [HUM_STAGES-1:0] r_v;
    logic [HUM_STAGES-1:0] w_en;

    logic signed [31:0] w_x, w_h1, w_h2, w_h3, w_h5, w_h6, w_h4sh, w_rhsh;
    logic signed [31:0] r1_hx, r1_m6, r1_m3;
    logic        [15:0] r1_rh;
    logic signed [31:0] n_psum;
    logic signed [31:0] r2_p, r2_q1, r2_q2;
    logic signed [31:0] r3_qm, r3_p;
    logic signed [31:0] n_q;
    logic signed [31:0] r4_qh, r4_p;
    logic signed [31:0] n_qs;
    logic signed [31:0] r5_pq;
    logic signed [31:0] n_s;
    logic signed [31:0] r6_ss, r6_pq;
    logic signed [31:0] r7_t, r7_pq;
    logic signed [31:0] n_hx, n_hc;
    logic        [16:0] r8_hum;

    // Fine and centidegree temperature ride along with each item.
    logic [31:0] r_tf [HUM_STAGES];
    logic [23:0] r_tc [HUM_STAGES];

    always_comb begin
        w_en[HUM_STAGES-1] = !r_v[HUM_STAGES-1] || !i_stall;
        for (int k = HUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < HUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_tf[0] <= i_res.tf;
            r_tc[0] <= i_res.tc;
        end
        for (int k = 1; k < HUM_STAGES; k++) begin
            if (w_en[k]) begin
                r_tf[k] <= r_tf[k-1];
                r_tc[k] <= r_tc[k-1];
            end
        end
    end

    assign w_x    = i_res.x;
    assign w_h1   = {24'd0, i_cal.h1};
    assign w_h2   = {{16{i_cal.h2[15]}}, i_cal.h2};
    assign w_h3   = {24'd0, i_cal.h3};
    assign w_h5   = {20'd0, i_cal.h5};
    assign w_h6   = {{24{i_cal.h6[7]}}, i_cal.h6};
    assign w_h4sh = {i_cal.h4, 20'd0};
    assign w_rhsh = {2'd0, r1_rh, 14'd0};

    assign n_psum = w_rhsh - w_h4sh - r1_hx + C_P_ROUND;
    assign n_q    = (r3_qm >>> 10) + C_Q_OFS;
    assign n_qs   = (r4_qh + C_QH_ROUND) >>> 14;
    assign n_s    = r5_pq >>> 15;
    assign n_hx   = r7_pq - (r7_t >>> 4);

    // Clamp the accumulator to the valid humidity range before the final shift.
    always_comb begin
        if (n_hx[31]) begin
            n_hc = '0;
        end else if (n_hx > C_HUM_MAX) begin
            n_hc = C_HUM_MAX;
        end else begin
            n_hc = n_hx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_hx <= w_x * w_h5;
            r1_m6 <= w_x * w_h6;
            r1_m3 <= w_x * w_h3;
            r1_rh <= i_res.rh;
        end
        if (w_en[1]) begin
            r2_p  <= n_psum >>> 15;
            r2_q1 <= r1_m6 >>> 10;
            r2_q2 <= (r1_m3 >>> 11) + C_Q2_OFS;
        end
        if (w_en[2]) begin
            r3_qm <= r2_q1 * r2_q2;
            r3_p  <= r2_p;
        end
        if (w_en[3]) begin
            r4_qh <= n_q * w_h2;
            r4_p  <= r3_p;
        end
        if (w_en[4]) begin
            r5_pq <= r4_p * n_qs;
        end
        if (w_en[5]) begin
            r6_ss <= n_s * n_s;
            r6_pq <= r5_pq;
        end
        if (w_en[6]) begin
            r7_t  <= (r6_ss >>> 7) * w_h1;
            r7_pq <= r6_pq;
        end
        if (w_en[7]) begin
            r8_hum <= n_hc[28:12];
        end
    end

    assign o_valid             = r_v[HUM_STAGES-1];
    assign o_humidity_q10      = r8_hum;
    assign o_fine_temperature  = r_tf[HUM_STAGES-1];
    assign o_temperature_centi = r_tc[HUM_STAGES-1];

endmodule
`default_nettype wire

// ===== sv/temp_humidity_compensation_top.sv =====
// Top level of the temperature and humidity compensation pipeline.
// An accepted item passes through 4 temperature and 8 humidity stages to its result.
// Throughput: one item per cycle while i_stall is low; each stage holds one item and moves when the next frees up.
// The chain of dependent 32-bit multiplies sets the stage count.
// Reset clears all stage valid bits and the calibration registers to zero.
`default_nettype none
`include "assert_macros.svh"
module temp_humidity_compensation_top
    import thc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic        [19:0] i_raw_temperature,
    input  wire logic        [15:0] i_raw_humidity,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed      [23:0] o_temperature_centi,
    output logic             [16:0] o_humidity_q10,
    output logic signed      [31:0] o_fine_temperature,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic        [3:0]  i_cfg_index,
    input  wire logic        [15:0] i_cfg_data
);

    t_cal               w_cal;
    t_temp_res          w_temp_res;
    logic               w_temp_valid;
    logic               w_hum_stall;
    logic signed [31:0] w_tc_sum, w_tc_chk;
    logic               w_hum_ok, w_tc_ok;

    assign o_cfg_ready = 1'b1;

    thc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cal       (w_cal)
    );

    thc_temp_pipe u_temp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cal             (w_cal),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_humidity    (i_raw_humidity),
        .o_valid           (w_temp_valid),
        .i_stall           (w_hum_stall),
        .o_res             (w_temp_res)
    );

    thc_hum_pipe u_hum (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cal               (w_cal),
        .i_valid             (w_temp_valid),
        .o_stall             (w_hum_stall),
        .i_res               (w_temp_res),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_q10      (o_humidity_q10),
        .o_fine_temperature  (o_fine_temperature)
    );

    // Recompute the centidegree value from the delivered fine temperature.
    assign w_tc_sum = o_fine_temperature + (o_fine_temperature <<< 2) + C_TC_ROUND;
    assign w_tc_chk = w_tc_sum >>> 8;
    assign w_tc_ok  = w_tc_chk[23:0] == o_temperature_centi;
    assign w_hum_ok = o_humidity_q10 <= 17'd102400;

    `ASSERT_IMPLY(a_hum_range, i_clk, i_rst_n, o_valid, w_hum_ok, "humidity out of range")
    `ASSERT_IMPLY(a_tc_match, i_clk, i_rst_n, o_valid, w_tc_ok, "centidegree value off")
    `ASSERT_IMPLY(a_empty_ready, i_clk, i_rst_n, !o_valid, !o_stall, "stall while output empty")

endmodule
`default_nettype wire

// ===== tb/tb_temp_humidity_compensation_top.sv =====
// Self-checking testbench for the temperature and humidity compensation pipeline.
`timescale 1ns / 100ps
module tb_temp_humidity_compensation_top
    import thc_pkg::*;
();

    localparam int          LATENCY_CYCLES     = 12;
    localparam int          CYCLE_LIMIT        = 200000;
    localparam int          RANDOM_PHASES      = 8;
    localparam int          ITEMS_PER_PHASE    = 212;
    localparam int          DIRECTED_ROWS      = 19;
    localparam int          IDLE_PERCENT       = 19;
    localparam int          MAX_PRINTED        = 40;
    localparam logic [3:0]  REG_FIRST_UNMAPPED = 4'd8;
    localparam logic [3:0]  REG_LAST_UNMAPPED  = 4'd15;

    typedef struct packed {
        logic signed [23:0] tc;
        logic        [16:0] hum;
        logic signed [31:0] tf;
    } t_reading;

    // A row names its calibration set, loaded when it differs from the active one, then sends
    // one item. Rows marked fixed carry their expected reading; the rest are predicted.
    typedef struct packed {
        logic        [2:0]  cal_set;
        logic        [19:0] rt;
        logic        [15:0] rh;
        logic               fixed;
        logic signed [23:0] tc;
        logic        [16:0] hum;
        logic signed [31:0] tf;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic        [19:0] i_raw_temperature;
    logic        [15:0] i_raw_humidity;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [23:0] o_temperature_centi;
    logic        [16:0] o_humidity_q10;
    logic signed [31:0] o_fine_temperature;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic        [3:0]  i_cfg_index;
    logic        [15:0] i_cfg_data;

    logic [15:0] cal_mirror [0:15];
    t_reading    pending_readings [$];
    t_reading    want_reading;
    bit          gaps_on;
    int          mismatch_count;
    int          items_sent;
    int          readings_checked;
    int          cal_sets_loaded;
    int          cycle_count;

    t_stim_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{3'd0, 20'h00000, 16'h0000, 1'b1, 24'sd0, 17'd0, 32'sd0},
        '{3'd0, 20'hFFFFF, 16'hFFFF, 1'b1, 24'sd0, 17'd0, 32'sd0},
        '{3'd0, 20'h80000, 16'h8000, 1'b1, 24'sd0, 17'd0, 32'sd0},
        '{3'd1, 20'd519888, 16'd27646, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd1, 20'h00000, 16'h0000, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd1, 20'hFFFFF, 16'hFFFF, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd1, 20'd519888, 16'h0000, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd1, 20'd519888, 16'hFFFF, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd1, 20'd415148, 16'd20000, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd1, 20'd600000, 16'd40000, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd2, 20'h00000, 16'h0000, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd2, 20'hFFFFF, 16'hFFFF, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd2, 20'hAAAAA, 16'h5555, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd3, 20'h00000, 16'hFFFF, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd3, 20'hFFFFF, 16'h0000, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd3, 20'h55555, 16'hAAAA, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd4, 20'h00000, 16'h0000, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd4, 20'hFFFFF, 16'hFFFF, 1'b0, 24'sd0, 17'd0, 32'sd0},
        '{3'd4, 20'h12345, 16'h8000, 1'b0, 24'sd0, 17'd0, 32'sd0}
    };

    temp_humidity_compensation_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_raw_temperature   (i_raw_temperature),
        .i_raw_humidity      (i_raw_humidity),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_q10      (o_humidity_q10),
        .o_fine_temperature  (o_fine_temperature),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Integer compensation; every intermediate is a 32-bit signed value so that
    // products wrap and right shifts are arithmetic.
    function automatic t_reading compensate(input logic [19:0] raw_t, input logic [15:0] raw_h);
        logic signed [31:0] rt, rh, t1, t2, t3, h1, h2, h3, h4, h5, h6;
        logic signed [31:0] b, v1, v2, tf, tc, x, p, q1, q2, q, acc, s;
        t_reading r;
        rt = {12'd0, raw_t};
        rh = {16'd0, raw_h};
        t1 = {16'd0, cal_mirror[REG_TEMP_CAL_1]};
        t2 = {{16{cal_mirror[REG_TEMP_CAL_2][15]}}, cal_mirror[REG_TEMP_CAL_2]};
        t3 = {{16{cal_mirror[REG_TEMP_CAL_3][15]}}, cal_mirror[REG_TEMP_CAL_3]};
        h1 = {24'd0, cal_mirror[REG_HUM_CAL_1_AND_3][7:0]};
        h3 = {24'd0, cal_mirror[REG_HUM_CAL_1_AND_3][15:8]};
        h2 = {{16{cal_mirror[REG_HUM_CAL_2][15]}}, cal_mirror[REG_HUM_CAL_2]};
        h4 = {20'd0, cal_mirror[REG_HUM_CAL_4][11:0]};
        h5 = {20'd0, cal_mirror[REG_HUM_CAL_5][11:0]};
        h6 = {{24{cal_mirror[REG_HUM_CAL_6][7]}}, cal_mirror[REG_HUM_CAL_6][7:0]};

        v1 = (((rt >>> 3) - (t1 <<< 1)) * t2) >>> 11;
        b  = (rt >>> 4) - t1;
        v2 = (((b * b) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        tc = (tf * 32'sd5 + C_TC_ROUND) >>> 8;

        x   = tf - C_TF_OFFSET;
        p   = ((rh <<< 14) - (h4 <<< 20) - h5 * x + C_P_ROUND) >>> 15;
        q1  = (x * h6) >>> 10;
        q2  = ((x * h3) >>> 11) + C_Q2_OFS;
        q   = ((q1 * q2) >>> 10) + C_Q_OFS;
        q   = (q * h2 + C_QH_ROUND) >>> 14;
        acc = p * q;
        s   = acc >>> 15;
        acc = acc - ((((s * s) >>> 7) * h1) >>> 4);
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > C_HUM_MAX) begin
            acc = C_HUM_MAX;
        end

        r.tc  = tc[23:0];
        r.hum = acc[28:12];
        r.tf  = tf;
        return r;
    endfunction

    function automatic logic [7:0][15:0] cal_set_words(input logic [2:0] set_id);
        // Words in register order, highest index first.
        case (set_id)
            3'd1:    return {16'h001E, 16'h0032, 16'h0139, 16'h016A,
                             16'h004B, 16'hFC18, 16'h6743, 16'h6B70};
            3'd2:    return {8{16'hFFFF}};
            3'd3:    return {16'h007F, 16'h0000, 16'h0000, 16'h7FFF,
                             16'h00FF, 16'h7FFF, 16'h7FFF, 16'h0000};
            3'd4:    return {16'hFF80, 16'hF800, 16'hF800, 16'h8000,
                             16'hFF00, 16'h8000, 16'h8000, 16'hFFFF};
            default: return '0;
        endcase
    endfunction

    function automatic logic [7:0][15:0] plausible_cal_words();
        logic [7:0][15:0] w;
        int t3;
        t3 = $urandom_range(2500) - 1500;
        w[REG_TEMP_CAL_1[2:0]]      = 16'(26000 + $urandom_range(4000));
        w[REG_TEMP_CAL_2[2:0]]      = 16'(24000 + $urandom_range(4000));
        w[REG_TEMP_CAL_3[2:0]]      = t3[15:0];
        w[REG_HUM_CAL_1_AND_3[2:0]] = {8'($urandom_range(10)), 8'($urandom_range(100))};
        w[REG_HUM_CAL_2[2:0]]       = 16'(300 + $urandom_range(120));
        w[REG_HUM_CAL_4[2:0]]       = 16'(250 + $urandom_range(150));
        w[REG_HUM_CAL_5[2:0]]       = 16'($urandom_range(100));
        w[REG_HUM_CAL_6[2:0]]       = 16'($urandom_range(40));
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        end
    endtask

    task automatic write_cal(input logic [3:0] index, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            REG_HUM_CAL_4, REG_HUM_CAL_5: cal_mirror[index] = {4'd0, data[11:0]};
            REG_HUM_CAL_6:                cal_mirror[index] = {8'd0, data[7:0]};
            REG_TEMP_CAL_1, REG_TEMP_CAL_2, REG_TEMP_CAL_3,
            REG_HUM_CAL_1_AND_3, REG_HUM_CAL_2: cal_mirror[index] = data;
            default: ;
        endcase
    endtask

    // Loads all eight calibration words, then pokes one unmapped index that must be ignored.
    task automatic load_calibration(input logic [7:0][15:0] words);
        for (int i = 0; i < 8; i++) begin
            write_cal(4'(i), words[i]);
        end
        write_cal(4'($urandom_range(REG_LAST_UNMAPPED, REG_FIRST_UNMAPPED)), 16'($urandom()));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cal_sets_loaded++;
    endtask

    // Holds the sender off until every reading in flight has been checked.
    task automatic wait_for_readings();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(input logic [19:0] rt, input logic [15:0] rh, input t_reading want);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid           = 1'b1;
        i_raw_temperature = rt;
        i_raw_humidity    = rh;
        do @(posedge i_clk); while (o_stall);
        pending_readings.push_back(want);
        items_sent++;
    endtask

    task automatic send_random_item(input bit plausible);
        logic [19:0] rt;
        logic [15:0] rh;
        int pick;
        pick = $urandom_range(99);
        if (plausible && pick < 85) begin
            rt = 20'($urandom_range(620000, 380000));
            rh = 16'($urandom_range(55000, 15000));
        end else if (pick < 95) begin
            rt = 20'($urandom());
            rh = 16'($urandom());
        end else begin
            rt = $urandom_range(1) ? 20'hFFFFF : 20'h00000;
            rh = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        send_item(rt, rh, compensate(rt, rh));
    endtask

    always @(negedge i_clk) begin
        i_stall <= gaps_on && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("reading with nothing expected, fine temperature",
                                o_fine_temperature, 0);
            end else begin
                want_reading = pending_readings.pop_front();
                readings_checked++;
                if (o_temperature_centi !== want_reading.tc) begin
                    report_mismatch("temperature_centi", o_temperature_centi, want_reading.tc);
                end
                if (o_humidity_q10 !== want_reading.hum) begin
                    report_mismatch("humidity_q10", o_humidity_q10, want_reading.hum);
                end
                if (o_fine_temperature !== want_reading.tf) begin
                    report_mismatch("fine_temperature", o_fine_temperature, want_reading.tf);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d readings outstanding",
                     cycle_count, pending_readings.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [2:0] active_set;
        bit         plausible;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_raw_temperature = '0;
        i_raw_humidity    = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = REG_TEMP_CAL_1;
        i_cfg_data        = '0;
        gaps_on           = 1'b1;
        mismatch_count    = 0;
        items_sent        = 0;
        readings_checked  = 0;
        cal_sets_loaded   = 0;
        active_set        = 3'd0;
        for (int i = 0; i < 16; i++) begin
            cal_mirror[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: reset calibration first, then fixed sets including the extremes.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].cal_set != active_set) begin
                wait_for_readings();
                active_set = directed_rows[r].cal_set;
                load_calibration(cal_set_words(active_set));
            end
            if (directed_rows[r].fixed) begin
                send_item(directed_rows[r].rt, directed_rows[r].rh,
                          '{directed_rows[r].tc, directed_rows[r].hum, directed_rows[r].tf});
            end else begin
                send_item(directed_rows[r].rt, directed_rows[r].rh,
                          compensate(directed_rows[r].rt, directed_rows[r].rh));
            end
        end

        // Random phases, each under a fresh calibration loaded while the pipeline is empty.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_for_readings();
            plausible = (ph % 3 != 1);
            if (plausible) begin
                load_calibration(plausible_cal_words());
            end else begin
                load_calibration({16'($urandom()), 16'($urandom()), 16'($urandom()),
                                  16'($urandom()), 16'($urandom()), 16'($urandom()),
                                  16'($urandom()), 16'($urandom())});
            end
            // One whole phase runs back to back with no gaps on either side.
            gaps_on = (ph != 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 5 && n == ITEMS_PER_PHASE / 2) begin
                    wait_for_readings();
                end
                send_random_item(plausible);
            end
        end
        gaps_on = 1'b1;

        wait_for_readings();
        $display("Sent %0d raw samples under %0d calibration loads; %0d readings compared.",
                 items_sent, cal_sets_loaded, readings_checked);
        $display("Field mismatches: %0d, readings left outstanding: %0d.",
                 mismatch_count, pending_readings.size());
        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
